FILE: src/sphb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphb_pkg
// Shared types and constants for the scatter point histogram binner.
// ----------------------------------------------------------------------------
package sphb_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_BINS_X     = 3'd0;
    localparam logic [2:0] CFG_BINS_Y     = 3'd1;
    localparam logic [2:0] CFG_BINS_Z     = 3'd2;
    localparam logic [2:0] CFG_DATA_BINS  = 3'd3;
    localparam logic [2:0] CFG_RANGE_X    = 3'd4;
    localparam logic [2:0] CFG_RANGE_Y    = 3'd5;
    localparam logic [2:0] CFG_RANGE_Z    = 3'd6;
    localparam logic [2:0] CFG_RANGE_DATA = 3'd7;

    // input actions
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // axis walk order: z, y, x, data
    localparam logic [1:0] AXIS_Z    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_X    = 2'd2;
    localparam logic [1:0] AXIS_DATA = 2'd3;

    localparam int BINS_W  = 13;
    localparam int ADDR_W  = 12;
    localparam int COUNT_W = 32;
    localparam int Q_W     = 14;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_PREP = 8'b0000_0100,
        S_DSET = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_RD   = 8'b0100_0000,
        S_WB   = 8'b1000_0000
    } state_t;

endpackage

FILE: src/scatter_point_histogram_binner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_point_histogram_binner_core
// Bins points into a count store of up to four axes, with read-and-clear.
// ----------------------------------------------------------------------------
// One item is worked at a time. A read-and-clear passes through a store read
// state and a write-back state before its result is registered. An add walks
// the four axes through a shared multiplier for the scaled numerator and a
// restoring divider that yields one quotient bit a cycle: a binned axis takes
// prepare, divider setup, 14 quotient steps and accumulate; an axis that is
// not binned or needs no division takes only prepare and accumulate. The
// read-modify-write of the count store follows; while an earlier result is
// stalled, write-back waits until it is taken. After reset the count store is
// cleared one entry a cycle while s_ready stays low; configuration writes are
// taken at any time.
module scatter_point_histogram_binner_core
    import sphb_pkg::*;
#(
    parameter int MAX_BINS   = 4096,
    parameter int COORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [63:0]        cfg_wdata,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic signed [31:0] s_data_value,
    input  logic [11:0]        s_read_address,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_bin_address,
    output logic [31:0]        m_bin_count,
    output logic               m_out_of_range
);

    localparam int AW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int SW = CW + BINS_W + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_BINS - 1);
    localparam logic [CW-1:0] SAT_MAX  = CW'(MAX_BINS);

    function automatic logic signed [33:0] sext(input logic [31:0] v);
        logic signed [COORD_BITS-1:0] t;
        t = $signed(v[COORD_BITS-1:0]);
        return 34'(t);
    endfunction

    // configuration registers
    logic [BINS_W-1:0] bins_x_reg, bins_y_reg, bins_z_reg, data_bins_reg;
    logic [63:0]       range_x_reg, range_y_reg, range_z_reg, range_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bins_x_reg     <= BINS_W'(1);
            bins_y_reg     <= BINS_W'(1);
            bins_z_reg     <= BINS_W'(1);
            data_bins_reg  <= BINS_W'(1);
            range_x_reg    <= '0;
            range_y_reg    <= '0;
            range_z_reg    <= '0;
            range_data_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_BINS_X:     bins_x_reg     <= cfg_wdata[BINS_W-1:0];
                CFG_BINS_Y:     bins_y_reg     <= cfg_wdata[BINS_W-1:0];
                CFG_BINS_Z:     bins_z_reg     <= cfg_wdata[BINS_W-1:0];
                CFG_DATA_BINS:  data_bins_reg  <= cfg_wdata[BINS_W-1:0];
                CFG_RANGE_X:    range_x_reg    <= cfg_wdata;
                CFG_RANGE_Y:    range_y_reg    <= cfg_wdata;
                CFG_RANGE_Z:    range_z_reg    <= cfg_wdata;
                CFG_RANGE_DATA: range_data_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and working registers
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg;
    logic [1:0]         axis_reg;
    logic               action_reg;
    logic [31:0]        x_reg, y_reg, z_reg, d_reg;
    logic [45:0]        num_reg;
    logic [32:0]        span_reg;
    logic [BINS_W-1:0]  nbm1_reg, eff_reg;
    logic               skip_reg, ovf_reg;
    logic [47:0]        rem_reg, dsh_reg;
    logic [Q_W-1:0]     q_reg;
    logic [3:0]         cnt_reg;
    logic [ADDR_W-1:0]  lo_reg;
    logic [CW-1:0]      sat_reg;
    logic [AW-1:0]      idx_reg;
    logic               oor_reg;
    logic               m_valid_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_oor_reg;

    // count store
    logic [COUNT_W-1:0] mem [MAX_BINS];
    logic [COUNT_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

    logic s_fire, wb_fire;
    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign wb_fire = (state_reg == S_WB) && (!m_valid_reg || m_ready);

    // axis selection
    logic [BINS_W-1:0] sel_bins;
    logic [63:0]       sel_range;
    logic [31:0]       sel_val;

    always_comb begin
        case (axis_reg)
            AXIS_Z: begin
                sel_bins = bins_z_reg; sel_range = range_z_reg; sel_val = z_reg;
            end
            AXIS_Y: begin
                sel_bins = bins_y_reg; sel_range = range_y_reg; sel_val = y_reg;
            end
            AXIS_X: begin
                sel_bins = bins_x_reg; sel_range = range_x_reg; sel_val = x_reg;
            end
            default: begin
                sel_bins = data_bins_reg; sel_range = range_data_reg; sel_val = d_reg;
            end
        endcase
    end

    // offset, span and scaled numerator of the selected axis
    logic signed [33:0] v_s, lo_s, hi_s, span_s, diff_s, span_a, diff_a;
    logic [BINS_W-1:0]  eff_bins, nbm1;
    logic               skip_axis;
    logic [45:0]        num_prod;

    always_comb begin
        v_s    = sext(sel_val);
        lo_s   = sext(sel_range[31:0]);
        hi_s   = sext(sel_range[63:32]);
        span_s = hi_s - lo_s;
        diff_s = v_s - lo_s;
        if (span_s < 0) begin
            span_a = -span_s;
            diff_a = -diff_s;
        end else begin
            span_a = span_s;
            diff_a = diff_s;
        end
        eff_bins  = (sel_bins == '0) ? BINS_W'(1) : sel_bins;
        nbm1      = eff_bins - BINS_W'(1);
        skip_axis = (nbm1 == '0) || (span_s == 0) || (diff_a <= 0);
        num_prod  = 46'(nbm1 * diff_a[32:0]);
    end

    // divider setup and step
    logic [47:0] dividend, divisor_top;
    logic        div_ge;
    logic [47:0] rem_sub;

    always_comb begin
        dividend    = {1'b0, num_reg, 1'b0} + 48'(span_reg);
        divisor_top = {span_reg, 1'b0, 14'b0};
        div_ge      = rem_reg >= dsh_reg;
        rem_sub     = rem_reg - dsh_reg;
    end

    // axis bin and address accumulation
    logic [BINS_W-1:0] axis_bin;
    logic [ADDR_W-1:0] lo_acc;
    logic [SW-1:0]     sat_acc;

    always_comb begin
        if (skip_reg) begin
            axis_bin = '0;
        end else if (ovf_reg || (q_reg > {1'b0, nbm1_reg})) begin
            axis_bin = nbm1_reg;
        end else begin
            axis_bin = q_reg[BINS_W-1:0];
        end
        lo_acc  = ADDR_W'(lo_reg * eff_reg + ADDR_W'(axis_bin));
        sat_acc = SW'(sat_reg * eff_reg) + SW'(axis_bin);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:  if (clr_cnt_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE: if (s_fire) state_next = (s_action == ACT_READ) ? S_RD : S_PREP;
            S_PREP: state_next = skip_axis ? S_ACC : S_DSET;
            S_DSET: state_next = S_DIV;
            S_DIV:  if (cnt_reg == '0) state_next = S_ACC;
            S_ACC:  state_next = (axis_reg == AXIS_DATA) ? S_RD : S_PREP;
            S_RD:   state_next = S_WB;
            S_WB:   if (wb_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (wb_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                action_reg <= s_action;
                x_reg      <= s_coord_x;
                y_reg      <= s_coord_y;
                z_reg      <= s_coord_z;
                d_reg      <= s_data_value;
                axis_reg   <= AXIS_Z;
                lo_reg     <= (s_action == ACT_READ) ? s_read_address : '0;
                sat_reg    <= '0;
                idx_reg    <= AW'(s_read_address);
                oor_reg    <= 32'(s_read_address) >= 32'(MAX_BINS);
            end
            S_PREP: begin
                num_reg  <= num_prod;
                span_reg <= span_a[32:0];
                nbm1_reg <= nbm1;
                eff_reg  <= eff_bins;
                skip_reg <= skip_axis;
            end
            S_DSET: begin
                ovf_reg <= dividend >= divisor_top;
                rem_reg <= dividend;
                dsh_reg <= {1'b0, span_reg, 1'b0, 13'b0};
                q_reg   <= '0;
                cnt_reg <= 4'(Q_W - 1);
            end
            S_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_sub;
                end
                q_reg   <= {q_reg[Q_W-2:0], div_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 4'd1;
            end
            S_ACC: begin
                lo_reg   <= lo_acc;
                sat_reg  <= (sat_acc >= SW'(MAX_BINS)) ? SAT_MAX : sat_acc[CW-1:0];
                idx_reg  <= AW'(sat_acc);
                oor_reg  <= sat_acc >= SW'(MAX_BINS);
                axis_reg <= axis_reg + 2'd1;
            end
            default: ;
        endcase
    end

    // read-modify-write of the addressed count
    logic [COUNT_W-1:0] new_count;

    always_comb begin
        new_count = (rd_data_reg == COUNT_MAX) ? COUNT_MAX : rd_data_reg + COUNT_W'(1);
        if (state_reg == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = wb_fire && !oor_reg;
            mem_waddr = idx_reg;
            mem_wdata = (action_reg == ACT_READ) ? '0 : new_count;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (wb_fire) begin
            m_addr_reg <= lo_reg;
            m_oor_reg  <= oor_reg;
            if (oor_reg) begin
                m_count_reg <= '0;
            end else if (action_reg == ACT_READ) begin
                m_count_reg <= rd_data_reg;
            end else begin
                m_count_reg <= new_count;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bin_address  = m_addr_reg;
    assign m_bin_count    = m_count_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

FILE: src/sphb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphb_checker
// Port-level checks for the histogram binner, bound to the binner core.
// ----------------------------------------------------------------------------
module sphb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_bin_address,
    input logic [31:0] m_bin_count,
    input logic        m_out_of_range
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_count)
            && $stable(m_bin_address) && $stable(m_out_of_range))
        else $error("stalled result changed");

    // an address outside the store counts nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_bin_count == 32'd0)
        else $error("out of range result with nonzero count");

    // store clearing blocks input right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during store clearing");

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer while item in work");

endmodule

bind scatter_point_histogram_binner_core sphb_checker u_sphb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_bin_address  (m_bin_address),
    .m_bin_count    (m_bin_count),
    .m_out_of_range (m_out_of_range)
);
